// ===== rtl/amsd_pkg.sv =====
// Shared constants and types for the accelerometer motion and stop detector.
package amsd_pkg;

   localparam int RING_DEPTH = 16;
   localparam int IDX_W      = $clog2(RING_DEPTH);
   localparam int SAMP_W     = 7;
   localparam int SUM_W      = $clog2(RING_DEPTH) + SAMP_W;
   localparam int RAW_W      = 16;
   localparam int CNT_W      = 16;
   localparam int THR_W      = 7;
   localparam int EVT_W      = 2;
   localparam int CSR_IDX_W  = 2;

   // divide by 1000 as multiply by ceil(2^25 / 1000), exact for |raw| <= 32768
   localparam logic [RAW_W-1:0] SCALE_MUL   = 16'd33555;
   localparam int               SCALE_SHIFT = 25;

   localparam logic [EVT_W-1:0] EVT_NONE   = 2'd0;
   localparam logic [EVT_W-1:0] EVT_MOTION = 2'd1;
   localparam logic [EVT_W-1:0] EVT_STOP   = 2'd2;

   localparam logic [CSR_IDX_W-1:0] REG_FWD_THR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BWD_THR  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_STOP_CNT = 2'd2;

   localparam logic signed [THR_W-1:0] FWD_THR_RESET  = 7'sd5;
   localparam logic signed [THR_W-1:0] BWD_THR_RESET  = -7'sd1;
   localparam logic [CNT_W-1:0]        STOP_CNT_RESET = 16'd5000;

   typedef struct packed {
      logic                     valid;
      logic signed [SAMP_W-1:0] sample;
      logic [IDX_W-1:0]         idx;
      logic                     entry_valid;
      logic                     hot;
   } stage_type;

endpackage

// ===== rtl/amsd_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module amsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/accel_motion_stop_detector.sv =====
// Top level of the accelerometer motion and stop detector.
//
// req_ channel: one request per accelerometer X sample, with the extruder
// hot flag on req_tuser. rsp_ channel: exactly one event code per request,
// in request order (0 none, 1 motion detected, 2 printer stopped).
// csr_ channel: register writes (0 forward threshold, 1 backward threshold,
// 2 stop count); always ready, to be used only while no request is in flight.
// Each request passes the s1 stage register and then the response register.
// Throughput: one request per cycle while the receiver does not stall; the
// sample ring RAM is read when a request is accepted and written back when
// it leaves the s1 stage, at a different entry, so consecutive requests never collide.
// Reset clears the ring (per-entry valid bits), the running sum, average,
// counters and latch, and restores register defaults; no clearing pass.
// When the receiver stalls, the response register holds, the second stage
// holds one more request, and req_tready drops once both are full.
module accel_motion_stop_detector (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [15:0]                   req_tdata,   // [15:0] accel_sample
   input  logic                          req_tuser,   // [0] extruder_hot
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [7:0]                    rsp_tdata,   // [1:0] event_code
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [amsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                   csr_wdata
);
   import amsd_pkg::*;

   logic signed [THR_W-1:0]  fwd_thr_ff;
   logic signed [THR_W-1:0]  bwd_thr_ff;
   logic [CNT_W-1:0]         stop_cnt_ff;

   logic [IDX_W-1:0]         ring_idx_ff;
   logic [RING_DEPTH-1:0]    entry_valid_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SAMP_W-1:0] avg_ff;
   logic signed [SAMP_W-1:0] avg_in;
   logic                     armed_ff;
   logic                     armed_in;
   logic [CNT_W-1:0]         idle_ff;
   logic [CNT_W-1:0]         idle_in;
   logic                     latched_ff;
   logic                     latched_in;
   logic [EVT_W-1:0]         evt_in;

   stage_type                s1_ff;
   stage_type                s1_in;
   logic                     rsp_valid_ff;
   logic [EVT_W-1:0]         rsp_evt_ff;

   logic                     req_fire;
   logic                     s1_fire;
   logic [RAW_W-1:0]         raw_abs;
   logic [2*RAW_W-1:0]       prod;
   logic [SAMP_W-1:0]        quot;
   logic [SAMP_W-1:0]        rd_data;
   logic signed [SAMP_W-1:0] old_sample;
   logic signed [SUM_W-1:0]  avg_full;
   logic                     wrap;
   logic                     arm_now;

   localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(RING_DEPTH);
   localparam logic [IDX_W-1:0]        IDX_LAST = IDX_W'(RING_DEPTH - 1);

   assign csr_ready  = 1'b1;
   assign s1_fire    = s1_ff.valid && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_ff.valid || s1_fire;
   assign req_fire   = req_tvalid && req_tready;

   // scale: s = -(raw / 1000), truncating toward zero
   always_comb begin
      raw_abs = req_tdata[15] ? (~req_tdata + 16'd1) : req_tdata;
      prod    = (2*RAW_W)'(raw_abs) * (2*RAW_W)'(SCALE_MUL);
      quot    = prod[SCALE_SHIFT +: SAMP_W];
      s1_in.valid       = 1'b1;
      s1_in.sample      = req_tdata[15] ? $signed(quot) : -$signed(quot);
      s1_in.idx         = ring_idx_ff;
      s1_in.entry_valid = entry_valid_ff[ring_idx_ff];
      s1_in.hot         = req_tuser;
   end

   amsd_ram #(
      .WIDTH (SAMP_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_ff.idx),
      .wr_data (s1_ff.sample),
      .rd_en   (req_fire),
      .rd_addr (ring_idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      old_sample = s1_ff.entry_valid ? $signed(rd_data) : '0;
      sum_in     = sum_ff - SUM_W'(old_sample) + SUM_W'(s1_ff.sample);
      avg_full   = sum_in / DEPTH_S;
      wrap       = (s1_ff.idx == IDX_LAST);
      avg_in     = wrap ? avg_full[SAMP_W-1:0] : avg_ff;
      arm_now    = (avg_in >= fwd_thr_ff) || (avg_in <= bwd_thr_ff);
      armed_in   = armed_ff || arm_now;
      idle_in    = idle_ff;
      latched_in = latched_ff;
      evt_in     = EVT_NONE;
      if ((avg_in == '0) && !latched_ff) begin
         if (armed_in) begin
            idle_in  = '0;
            armed_in = 1'b0;
            evt_in   = EVT_MOTION;
         end else begin
            idle_in = idle_ff + 16'd1;
            if (idle_in == stop_cnt_ff) begin
               if (s1_ff.hot) begin
                  latched_in = 1'b1;
                  evt_in     = EVT_STOP;
               end else begin
                  idle_in = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_thr_ff     <= FWD_THR_RESET;
         bwd_thr_ff     <= BWD_THR_RESET;
         stop_cnt_ff    <= STOP_CNT_RESET;
         ring_idx_ff    <= '0;
         entry_valid_ff <= '0;
         sum_ff         <= '0;
         avg_ff         <= '0;
         armed_ff       <= 1'b0;
         idle_ff        <= '0;
         latched_ff     <= 1'b0;
         s1_ff.valid    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FWD_THR:  fwd_thr_ff  <= csr_wdata[THR_W-1:0];
               REG_BWD_THR:  bwd_thr_ff  <= csr_wdata[THR_W-1:0];
               REG_STOP_CNT: stop_cnt_ff <= csr_wdata[CNT_W-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            ring_idx_ff <= (ring_idx_ff == IDX_LAST) ? '0 : ring_idx_ff + IDX_W'(1);
            s1_ff       <= s1_in;
         end else if (s1_fire) begin
            s1_ff.valid <= 1'b0;
         end
         if (s1_fire) begin
            entry_valid_ff[s1_ff.idx] <= 1'b1;
            sum_ff       <= sum_in;
            avg_ff       <= avg_in;
            armed_ff     <= armed_in;
            idle_ff      <= idle_in;
            latched_ff   <= latched_in;
            rsp_valid_ff <= 1'b1;
            rsp_evt_ff   <= evt_in;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_evt_ff};

`ifndef NO_ASSERTIONS
   a_latch_holds: assert property (@(posedge clock) disable iff (reset)
      latched_ff |=> latched_ff)
      else $error("stop latch cleared without reset");

   a_latched_quiet: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && latched_ff) |=> (rsp_evt_ff == EVT_NONE))
      else $error("event reported while latched");

   a_no_ram_collision: assert property (@(posedge clock) disable iff (reset)
      (req_fire && s1_fire) |-> (ring_idx_ff != s1_ff.idx))
      else $error("ring read and write hit the same entry");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_ff.valid && rsp_valid_ff && !rsp_tready))
      else $error("request stalled with room in the pipeline");

   a_idx_follows: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ring_idx_ff != IDX_LAST) |=> (ring_idx_ff == s1_ff.idx + IDX_W'(1)))
      else $error("ring index did not advance");
`endif

endmodule
